// ===== hdl/dns_name_decompressor_assert.svh =====
// Assertion macros used by the decompressor RTL file.
`ifndef DNS_NAME_DECOMPRESSOR_ASSERT_SVH
`define DNS_NAME_DECOMPRESSOR_ASSERT_SVH
`ifndef SYNTH
`define DND_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dnd: implication check failed");
`define DND_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dnd: next-cycle check failed");
`else
`define DND_ASSERT_IMP(label, ante, cons)
`define DND_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/dnd_pkg.sv =====
`default_nettype none
package dnd_pkg;

	localparam int POS_W = 17;
	localparam int TLEN_W = 8;
	localparam int WIRE_W = 10;
	localparam int END_W = 10;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FORMAT = 2'd2;

	localparam logic [1:0] TAG_PTR = 2'b11;
	localparam logic [1:0] TAG_LABEL = 2'b00;
	localparam logic [7:0] CHAR_DOT = 8'h2E;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LEN,
		ST_WAIT_LEN,
		ST_WAIT_PTR,
		ST_RD_CH,
		ST_WAIT_CH,
		ST_FLUSH,
		ST_EM_RD,
		ST_EM_WAIT,
		ST_ERR
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/dns_name_decompressor.sv =====
// Load item: written in the cycle it is accepted; a new item is taken every cycle while idle.
// Decode item: each length byte, pointer hop and label character is read through the
// single message store read port, then the last word is flushed and each result is read out.
// A decode blocks new items until its last result sits in the output register.
// Reset clears the controller and output valid; message bytes are undefined until
// loaded (no clearing pass).
`default_nettype none
`include "dns_name_decompressor_assert.svh"
module dns_name_decompressor #(
	parameter int MSG_BYTES = 512,
	parameter int MAX_NAME_BYTES = 255,
	parameter int MAX_JUMPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // addr[8:0], data_byte[16:9], zero pad
	input  wire logic        s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [79:0] m_tdata,  // chars[63:0], char_count[67:64], next_offset[77:68]
	output logic             m_tlast,
	output logic      [1:0]  m_tuser   // status
);

	localparam int AW = $clog2(MSG_BYTES);
	localparam int TXT_WORDS = (MAX_NAME_BYTES + 7) / 8;
	localparam int TXT_AW = $clog2(TXT_WORDS);
	localparam int JW = $clog2(MAX_JUMPS + 1);
	localparam logic [dnd_pkg::POS_W-1:0] MSG_LIMIT = dnd_pkg::POS_W'(MSG_BYTES);

	dnd_pkg::state_t state_q, state_d;

	logic [dnd_pkg::POS_W-1:0]  pos_q;
	logic [5:0]                 hi_q;
	logic [5:0]                 cnt_q;
	logic [JW-1:0]              jumps_q;
	logic                       jumped_q;
	logic [dnd_pkg::WIRE_W-1:0] wire_q;
	logic [dnd_pkg::TLEN_W-1:0] tlen_q;
	logic [dnd_pkg::TLEN_W-1:0] rem_q;
	logic [2:0]                 fill_q;
	logic [TXT_AW-1:0]          widx_q;
	logic [TXT_AW-1:0]          ridx_q;
	logic [63:0]                word_q;
	logic [dnd_pkg::END_W-1:0]  end_q;
	logic [1:0]                 err_q;

	logic        out_valid_q;
	logic [63:0] out_chars_q;
	logic [3:0]  out_count_q;
	logic        out_last_q;
	logic [9:0]  out_next_q;
	logic [1:0]  out_status_q;

	logic       in_fire;
	logic       in_cmd;
	logic [8:0] in_addr;
	logic [7:0] in_byte;
	logic       slot_free;

	logic [dnd_pkg::POS_W-1:0] pos_inc;
	logic [7:0]                mem_rdata;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;

	logic              txt_we;
	logic [TXT_AW-1:0] txt_waddr;
	logic [63:0]       txt_wdata;
	logic              txt_re;
	logic [63:0]       txt_rdata;

	logic                       is_ptr;
	logic                       is_bad;
	logic                       is_end;
	logic                       pos_ok;
	logic                       ptr_ok;
	logic                       jump_over;
	logic [dnd_pkg::WIRE_W-1:0] wire_sum;
	logic                       name_over;
	logic [1:0]                 err_d;

	logic        app_en;
	logic [7:0]  app_char;
	logic [63:0] next_word;

	logic        em_last;
	logic [3:0]  em_count;
	logic        em_load;
	logic        err_load;

	assign in_cmd = s_tuser;
	assign in_addr = s_tdata[8:0];
	assign in_byte = s_tdata[16:9];
	assign s_tready = (state_q == dnd_pkg::ST_IDLE);
	assign in_fire = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;

	assign pos_inc = pos_q + dnd_pkg::POS_W'(1);
	assign pos_ok = pos_q < MSG_LIMIT;
	assign ptr_ok = pos_inc < MSG_LIMIT;
	assign is_ptr = (mem_rdata[7:6] == dnd_pkg::TAG_PTR);
	assign is_bad = mem_rdata[7] ^ mem_rdata[6];
	assign is_end = (mem_rdata == 8'd0);
	assign jump_over = jumps_q >= JW'(MAX_JUMPS);
	assign wire_sum = wire_q + dnd_pkg::WIRE_W'(mem_rdata) + dnd_pkg::WIRE_W'(2);
	assign name_over = wire_sum > dnd_pkg::WIRE_W'(MAX_NAME_BYTES);

	assign em_last = rem_q <= dnd_pkg::TLEN_W'(8);
	assign em_count = em_last ? rem_q[3:0] : 4'd8;

	always_comb begin
		next_word = word_q;
		for (int i = 0; i < 8; i++) begin
			if (fill_q == 3'(i)) begin
				next_word[i*8 +: 8] = word_q[i*8 +: 8] | app_char;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		err_d = dnd_pkg::STAT_OK;
		unique case (state_q)
			dnd_pkg::ST_IDLE: begin
				if (in_fire && in_cmd == dnd_pkg::CMD_DECODE) begin
					state_d = dnd_pkg::ST_RD_LEN;
				end
			end
			dnd_pkg::ST_RD_LEN: begin
				if (!pos_ok) begin
					state_d = dnd_pkg::ST_ERR;
					err_d = dnd_pkg::STAT_RANGE;
				end else begin
					state_d = dnd_pkg::ST_WAIT_LEN;
				end
			end
			dnd_pkg::ST_WAIT_LEN: begin
				priority if (is_ptr) begin
					if (!ptr_ok) begin
						state_d = dnd_pkg::ST_ERR;
						err_d = dnd_pkg::STAT_RANGE;
					end else if (jump_over) begin
						state_d = dnd_pkg::ST_ERR;
						err_d = dnd_pkg::STAT_FORMAT;
					end else begin
						state_d = dnd_pkg::ST_WAIT_PTR;
					end
				end else if (is_bad) begin
					state_d = dnd_pkg::ST_ERR;
					err_d = dnd_pkg::STAT_FORMAT;
				end else if (is_end) begin
					state_d = dnd_pkg::ST_FLUSH;
				end else if (name_over) begin
					state_d = dnd_pkg::ST_ERR;
					err_d = dnd_pkg::STAT_FORMAT;
				end else begin
					state_d = dnd_pkg::ST_RD_CH;
				end
			end
			dnd_pkg::ST_WAIT_PTR: state_d = dnd_pkg::ST_RD_LEN;
			dnd_pkg::ST_RD_CH: begin
				if (!pos_ok) begin
					state_d = dnd_pkg::ST_ERR;
					err_d = dnd_pkg::STAT_RANGE;
				end else begin
					state_d = dnd_pkg::ST_WAIT_CH;
				end
			end
			dnd_pkg::ST_WAIT_CH: begin
				state_d = (cnt_q == 6'd1) ? dnd_pkg::ST_RD_LEN : dnd_pkg::ST_RD_CH;
			end
			dnd_pkg::ST_FLUSH: state_d = dnd_pkg::ST_EM_RD;
			dnd_pkg::ST_EM_RD: state_d = dnd_pkg::ST_EM_WAIT;
			dnd_pkg::ST_EM_WAIT: begin
				if (slot_free) begin
					state_d = em_last ? dnd_pkg::ST_IDLE : dnd_pkg::ST_EM_RD;
				end
			end
			dnd_pkg::ST_ERR: begin
				if (slot_free) begin
					state_d = dnd_pkg::ST_IDLE;
				end
			end
			default: state_d = dnd_pkg::ST_IDLE;
		endcase
	end

	// memory strobes and appends
	always_comb begin
		mem_we = in_fire && in_cmd == dnd_pkg::CMD_LOAD
			&& dnd_pkg::POS_W'(in_addr) < MSG_LIMIT;
		mem_waddr = AW'(dnd_pkg::POS_W'(in_addr));
		mem_re = 1'b0;
		mem_raddr = pos_q[AW-1:0];
		txt_we = 1'b0;
		txt_waddr = widx_q;
		txt_wdata = next_word;
		txt_re = 1'b0;
		app_en = 1'b0;
		app_char = dnd_pkg::CHAR_DOT;
		em_load = 1'b0;
		err_load = 1'b0;
		unique case (state_q)
			dnd_pkg::ST_RD_LEN, dnd_pkg::ST_RD_CH: mem_re = pos_ok;
			dnd_pkg::ST_WAIT_LEN: begin
				mem_raddr = pos_inc[AW-1:0];
				mem_re = is_ptr && ptr_ok;
				app_en = !is_ptr && !is_bad && !is_end && !name_over
					&& tlen_q != dnd_pkg::TLEN_W'(0);
			end
			dnd_pkg::ST_WAIT_CH: begin
				app_en = 1'b1;
				app_char = mem_rdata;
			end
			dnd_pkg::ST_FLUSH: begin
				txt_we = fill_q != 3'd0;
				txt_wdata = word_q;
			end
			dnd_pkg::ST_EM_RD: txt_re = 1'b1;
			dnd_pkg::ST_EM_WAIT: em_load = slot_free;
			dnd_pkg::ST_ERR: err_load = slot_free;
			default: begin
			end
		endcase
		if (app_en && fill_q == 3'd7) begin
			txt_we = 1'b1;
		end
	end

	dnd_ram #(
		.WIDTH(8),
		.DEPTH(MSG_BYTES)
	) u_msg_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(in_byte),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	dnd_ram #(
		.WIDTH(64),
		.DEPTH(TXT_WORDS)
	) u_txt_ram (
		.clk  (clk),
		.we   (txt_we),
		.waddr(txt_waddr),
		.wdata(txt_wdata),
		.re   (txt_re),
		.raddr(ridx_q),
		.rdata(txt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dnd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			jumps_q <= '0;
			jumped_q <= 1'b0;
			wire_q <= '0;
			tlen_q <= '0;
			fill_q <= '0;
			widx_q <= '0;
			ridx_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (em_load || err_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (app_en) begin
				tlen_q <= tlen_q + dnd_pkg::TLEN_W'(1);
				fill_q <= fill_q + 3'd1;
				if (fill_q == 3'd7) begin
					widx_q <= widx_q + TXT_AW'(1);
				end
			end
			unique case (state_q)
				dnd_pkg::ST_IDLE: begin
					jumps_q <= '0;
					jumped_q <= 1'b0;
					wire_q <= '0;
					tlen_q <= '0;
					fill_q <= '0;
					widx_q <= '0;
				end
				dnd_pkg::ST_WAIT_LEN: begin
					if (is_ptr && ptr_ok && !jump_over) begin
						jumps_q <= jumps_q + JW'(1);
						jumped_q <= 1'b1;
					end else if (!is_ptr && !is_bad && !is_end && !name_over) begin
						wire_q <= wire_sum - dnd_pkg::WIRE_W'(1);
						cnt_q <= mem_rdata[5:0];
					end
				end
				dnd_pkg::ST_WAIT_CH: cnt_q <= cnt_q - 6'd1;
				dnd_pkg::ST_FLUSH: begin
					ridx_q <= '0;
					rem_q <= tlen_q;
				end
				dnd_pkg::ST_EM_WAIT: begin
					if (slot_free && !em_last) begin
						ridx_q <= ridx_q + TXT_AW'(1);
						rem_q <= rem_q - dnd_pkg::TLEN_W'(8);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (app_en) begin
			word_q <= (fill_q == 3'd7) ? 64'd0 : next_word;
		end
		if (state_d == dnd_pkg::ST_ERR && state_q != dnd_pkg::ST_ERR) begin
			err_q <= err_d;
		end
		unique case (state_q)
			dnd_pkg::ST_IDLE: begin
				pos_q <= dnd_pkg::POS_W'(in_addr);
				word_q <= 64'd0;
				end_q <= '0;
			end
			dnd_pkg::ST_WAIT_LEN: begin
				if (is_ptr) begin
					hi_q <= mem_rdata[5:0];
					if (!jumped_q) begin
						end_q <= dnd_pkg::END_W'(pos_q + dnd_pkg::POS_W'(2));
					end
				end else if (is_end) begin
					if (!jumped_q) begin
						end_q <= dnd_pkg::END_W'(pos_inc);
					end
				end else begin
					pos_q <= pos_inc;
				end
			end
			dnd_pkg::ST_WAIT_PTR: pos_q <= dnd_pkg::POS_W'({hi_q, mem_rdata});
			dnd_pkg::ST_WAIT_CH: pos_q <= pos_inc;
			default: begin
			end
		endcase
		if (em_load) begin
			out_chars_q <= (rem_q == dnd_pkg::TLEN_W'(0)) ? 64'd0 : txt_rdata;
			out_count_q <= em_count;
			out_last_q <= em_last;
			out_next_q <= em_last ? end_q : 10'd0;
			out_status_q <= dnd_pkg::STAT_OK;
		end else if (err_load) begin
			out_chars_q <= 64'd0;
			out_count_q <= 4'd0;
			out_last_q <= 1'b1;
			out_next_q <= 10'd0;
			out_status_q <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_next_q, out_count_q, out_chars_q};
	assign m_tlast = out_last_q;
	assign m_tuser = out_status_q;

	`DND_ASSERT_IMP(a_err_empty, m_tvalid && m_tuser != dnd_pkg::STAT_OK, m_tlast && m_tdata[67:0] == 68'd0)
	`DND_ASSERT_IMP(a_full_word, m_tvalid && !m_tlast, m_tdata[67:64] == 4'd8)
	`DND_ASSERT_IMP(a_jump_bound, 1'b1, jumps_q <= JW'(MAX_JUMPS))
	`DND_ASSERT_IMP(a_wire_bound, 1'b1, wire_q <= dnd_pkg::WIRE_W'(MAX_NAME_BYTES))
	`DND_ASSERT_NEXT(a_decode_start, in_fire && in_cmd == dnd_pkg::CMD_DECODE, state_q == dnd_pkg::ST_RD_LEN)

endmodule
`default_nettype wire

// ===== hdl/dnd_ram.sv =====
`default_nettype none
module dnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
